// ===== hw/rtl/btov_pkg.sv =====
`timescale 1ns / 1ps
package btov_pkg;

	localparam int COORD_BITS = 21;
	localparam int QUAT_BITS  = 16;
	localparam int QUAT_FRAC  = 14;

	// headroom for the gain of an unnormalised quaternion
	localparam int QGAIN  = (QUAT_BITS - 1 - QUAT_FRAC > 0) ? 2 * (QUAT_BITS - 1 - QUAT_FRAC) : 0;
	localparam int RIN_W  = COORD_BITS + 2 * QGAIN + 8;
	localparam int UV_W   = QUAT_BITS + RIN_W + 1;
	localparam int UUV_W  = QUAT_BITS + UV_W + 1;
	localparam int WUV_W  = QUAT_BITS + UV_W;
	localparam int VSH_W  = RIN_W + 2 * QUAT_FRAC;
	localparam int ACC_W  = ((UUV_W > VSH_W) ? UUV_W : VSH_W) + 3;
	localparam int ROUT_W = ACC_W + 1 - 2 * QUAT_FRAC;

	localparam int EDGE_W = COORD_BITS + 1;
	localparam int AXIS_W = COORD_BITS + 2;
	localparam int DOT_W  = 2 * COORD_BITS + 4;
	localparam int NRAW_W = 2 * COORD_BITS + 3;
	localparam int NRND_W = 2 * COORD_BITS + 2;
	localparam int NDOT_W = 3 * COORD_BITS + 6;

	localparam int VEC_W  = 3 * COORD_BITS;
	localparam int QV_W   = 4 * QUAT_BITS;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_MIN = -(1 << (COORD_BITS - 1));

	localparam logic [1:0] REG_BOX_CENTER = 2'd0;
	localparam logic [1:0] REG_BOX_ROT    = 2'd1;
	localparam logic [1:0] REG_BOX_HALF   = 2'd2;

	localparam logic [QV_W-1:0] ROT_RESET = QV_W'(1) << QUAT_FRAC;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [RIN_W-1:0]      rin_t;
	typedef logic signed [ROUT_W-1:0]     rout_t;
	typedef logic signed [EDGE_W-1:0]     edge_t;

	function automatic coord_t vec_at(input logic [VEC_W-1:0] w, input int k);
		return coord_t'(w[k*COORD_BITS +: COORD_BITS]);
	endfunction

	function automatic coord_t sat_coord(input rout_t x);
		rout_t hi_v;
		rout_t lo_v;
		hi_v = ROUT_W'(COORD_MAX);
		lo_v = ROUT_W'(COORD_MIN);
		if (x > hi_v) return COORD_BITS'(COORD_MAX);
		if (x < lo_v) return COORD_BITS'(COORD_MIN);
		return COORD_BITS'(x);
	endfunction

endpackage

// ===== hw/rtl/btov_rot.sv =====
`timescale 1ns / 1ps
module btov_rot (
	input  logic                     clk,
	input  logic [btov_pkg::QV_W-1:0] q,
	input  btov_pkg::rin_t           v [3],
	output btov_pkg::rout_t          r [3]
);
	import btov_pkg::*;

	localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W+1)'(1) <<< (2 * QUAT_FRAC - 1);

	logic signed [QUAT_BITS-1:0] qc [4];
	logic signed [QUAT_BITS-1:0] w_s1;
	logic signed [QUAT_BITS-1:0] u_s1 [3];
	rin_t                        v_s1 [3];
	rin_t                        v_s2 [3];
	logic signed [UV_W-1:0]      uv_n [3];
	logic signed [UV_W-1:0]      uv_s1 [3];
	logic signed [UUV_W-1:0]     uuv_n [3];
	logic signed [UUV_W-1:0]     uuv_s2 [3];
	logic signed [WUV_W-1:0]     wuv_n [3];
	logic signed [WUV_W-1:0]     wuv_s2 [3];
	logic signed [ACC_W-1:0]     acc [3];
	logic signed [ACC_W:0]       rnd [3];
	rout_t                       r_n [3];
	rout_t                       r_s3 [3];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qc[i] = q[i*QUAT_BITS +: QUAT_BITS];
		end
	end

	// u x v
	always_comb begin
		uv_n[0] = UV_W'(qc[2]) * UV_W'(v[2]) - UV_W'(qc[3]) * UV_W'(v[1]);
		uv_n[1] = UV_W'(qc[3]) * UV_W'(v[0]) - UV_W'(qc[1]) * UV_W'(v[2]);
		uv_n[2] = UV_W'(qc[1]) * UV_W'(v[1]) - UV_W'(qc[2]) * UV_W'(v[0]);
	end

	// u x (u x v) and w * (u x v)
	always_comb begin
		uuv_n[0] = UUV_W'(u_s1[1]) * UUV_W'(uv_s1[2]) - UUV_W'(u_s1[2]) * UUV_W'(uv_s1[1]);
		uuv_n[1] = UUV_W'(u_s1[2]) * UUV_W'(uv_s1[0]) - UUV_W'(u_s1[0]) * UUV_W'(uv_s1[2]);
		uuv_n[2] = UUV_W'(u_s1[0]) * UUV_W'(uv_s1[1]) - UUV_W'(u_s1[1]) * UUV_W'(uv_s1[0]);
		for (int k = 0; k < 3; k++) begin
			wuv_n[k] = WUV_W'(w_s1) * WUV_W'(uv_s1[k]);
		end
	end

	// round half up to the coordinate grid
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = (ACC_W'(v_s2[k]) <<< (2 * QUAT_FRAC))
				+ ((ACC_W'(wuv_s2[k]) + ACC_W'(uuv_s2[k])) <<< 1);
			rnd[k] = (ACC_W+1)'(acc[k]) + RND_BIAS;
			r_n[k] = ROUT_W'(rnd[k] >>> (2 * QUAT_FRAC));
		end
	end

	always_ff @(posedge clk) begin
		w_s1 <= qc[0];
		for (int k = 0; k < 3; k++) begin
			u_s1[k]   <= qc[k+1];
			v_s1[k]   <= v[k];
			uv_s1[k]  <= uv_n[k];
			v_s2[k]   <= v_s1[k];
			uuv_s2[k] <= uuv_n[k];
			wuv_s2[k] <= wuv_n[k];
			r_s3[k]   <= r_n[k];
		end
	end

	assign r = r_s3;

endmodule

// ===== hw/rtl/btov_edge.sv =====
`timescale 1ns / 1ps
module btov_edge (
	input  logic             clk,
	input  btov_pkg::coord_t h [3],
	input  btov_pkg::coord_t p [3][3],
	input  btov_pkg::edge_t  e [3],
	output logic             sep
);
	import btov_pkg::*;

	logic signed [AXIS_W-1:0] ax [3][3];
	logic signed [AXIS_W-1:0] ax_abs;
	logic signed [DOT_W-1:0]  dot_n [3][3];
	logic signed [DOT_W-1:0]  rad_n [3];
	logic                     live_n [3];
	logic signed [DOT_W-1:0]  dot_s1 [3][3];
	logic signed [DOT_W-1:0]  rad_s1 [3];
	logic                     live_s1 [3];
	logic signed [DOT_W-1:0]  lo;
	logic signed [DOT_W-1:0]  hi;
	logic                     sep_n;
	logic                     sep_s2;

	// the three cross axes of one edge with the box axes
	always_comb begin
		ax[0][0] = '0;
		ax[0][1] = -AXIS_W'(e[2]);
		ax[0][2] = AXIS_W'(e[1]);
		ax[1][0] = AXIS_W'(e[2]);
		ax[1][1] = '0;
		ax[1][2] = -AXIS_W'(e[0]);
		ax[2][0] = -AXIS_W'(e[1]);
		ax[2][1] = AXIS_W'(e[0]);
		ax[2][2] = '0;
	end

	always_comb begin
		ax_abs = '0;
		for (int a = 0; a < 3; a++) begin
			rad_n[a]  = '0;
			live_n[a] = 1'b0;
			for (int k = 0; k < 3; k++) begin
				ax_abs    = (ax[a][k] < 0) ? -ax[a][k] : ax[a][k];
				rad_n[a]  = rad_n[a] + DOT_W'(h[k]) * DOT_W'(ax_abs);
				live_n[a] = live_n[a] | (ax[a][k] != '0);
			end
			for (int j = 0; j < 3; j++) begin
				dot_n[a][j] = '0;
				for (int k = 0; k < 3; k++) begin
					dot_n[a][j] = dot_n[a][j] + DOT_W'(p[j][k]) * DOT_W'(ax[a][k]);
				end
			end
		end
	end

	always_comb begin
		lo    = '0;
		hi    = '0;
		sep_n = 1'b0;
		for (int a = 0; a < 3; a++) begin
			lo = dot_s1[a][0];
			hi = dot_s1[a][0];
			for (int j = 1; j < 3; j++) begin
				if (dot_s1[a][j] < lo) lo = dot_s1[a][j];
				if (dot_s1[a][j] > hi) hi = dot_s1[a][j];
			end
			sep_n = sep_n | (live_s1[a] & ((rad_s1[a] < lo) | (hi < -rad_s1[a])));
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			rad_s1[a]  <= rad_n[a];
			live_s1[a] <= live_n[a];
			for (int j = 0; j < 3; j++) begin
				dot_s1[a][j] <= dot_n[a][j];
			end
		end
		sep_s2 <= sep_n;
	end

	assign sep = sep_s2;

endmodule

// ===== hw/rtl/box_triangle_overlap_unit.sv =====
`timescale 1ns / 1ps
// channel   | handshake                         | payload
// ----------+-----------------------------------+----------------------------------------
// triangle  | start, busy (transfer: start & !busy) | tri_origin, tri_rotation, vertex_a/b/c
// result    | done (one-cycle strobe)           | overlaps
// config    | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// one triangle can enter every cycle; busy is never raised
// done follows the transfer down the valid pipeline, whose depth is set by the two three-stage
// quaternion rotations and the axis dot products that follow them
// arst_n clears the registers and the valid pipeline; data stages are not reset
// results cannot be held off, so the pipeline never stalls
module box_triangle_overlap_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [btov_pkg::VEC_W-1:0]   tri_origin,
	input  logic [btov_pkg::QV_W-1:0]    tri_rotation,
	input  logic [btov_pkg::VEC_W-1:0]   vertex_a,
	input  logic [btov_pkg::VEC_W-1:0]   vertex_b,
	input  logic [btov_pkg::VEC_W-1:0]   vertex_c,
	output logic                         done,
	output logic                         overlaps,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [btov_pkg::ADDR_W-1:0]  paddr,
	input  logic [btov_pkg::DATA_W-1:0]  pwdata,
	output logic [btov_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import btov_pkg::*;

	localparam int LAT = 12;

	logic [VEC_W-1:0] box_center_q;
	logic [QV_W-1:0]  box_rotation_inverse_q;
	logic [VEC_W-1:0] box_half_extents_q;
	logic [LAT-1:0]   vld_q;

	coord_t     h [3];
	coord_t     c [3];
	rin_t       v1 [3][3];
	rout_t      r1 [3][3];
	rin_t       w_s4 [3][3];
	rout_t      r2 [3][3];
	logic [VEC_W-1:0] origin_s1, origin_s2, origin_s3;
	coord_t     p_s8 [3][3];
	coord_t     p_s9 [3][3];
	edge_t      e_s9 [3][3];
	logic       face_n;
	logic       face_s9, face_s10, face_s11;
	logic       sep [3];
	logic signed [NRAW_W-1:0] n_n [3];
	logic signed [NRAW_W-1:0] n_s10 [3];
	coord_t     p0_s10 [3];
	logic signed [NRAW_W:0]   nb;
	logic signed [NRND_W-1:0] nr;
	logic signed [NRND_W:0]   na;
	logic signed [NDOT_W-1:0] d_n, rad_n;
	logic signed [NDOT_W-1:0] d_s11, rad_s11;
	logic       overlaps_s12;
	logic signed [COORD_BITS:0] lo_v, hi_v;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_center_q           <= '0;
			box_rotation_inverse_q <= ROT_RESET;
			box_half_extents_q     <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				REG_BOX_CENTER: box_center_q           <= pwdata[VEC_W-1:0];
				REG_BOX_ROT:    box_rotation_inverse_q <= pwdata[QV_W-1:0];
				REG_BOX_HALF:   box_half_extents_q     <= pwdata[VEC_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_BOX_CENTER: prdata = DATA_W'(box_center_q);
			REG_BOX_ROT:    prdata = DATA_W'(box_rotation_inverse_q);
			REG_BOX_HALF:   prdata = DATA_W'(box_half_extents_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			h[k]     = vec_at(box_half_extents_q, k);
			c[k]     = vec_at(box_center_q, k);
			v1[0][k] = RIN_W'(vec_at(vertex_a, k));
			v1[1][k] = RIN_W'(vec_at(vertex_b, k));
			v1[2][k] = RIN_W'(vec_at(vertex_c, k));
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_vert
		btov_rot u_rot_tri (
			.clk (clk),
			.q   (tri_rotation),
			.v   (v1[i]),
			.r   (r1[i])
		);
		btov_rot u_rot_box (
			.clk (clk),
			.q   (box_rotation_inverse_q),
			.v   (w_s4[i]),
			.r   (r2[i])
		);
	end

	// face axes from the triangle bounds in box space
	always_comb begin
		face_n = 1'b1;
		lo_v   = '0;
		hi_v   = '0;
		for (int k = 0; k < 3; k++) begin
			lo_v = (COORD_BITS+1)'(p_s8[0][k]);
			hi_v = (COORD_BITS+1)'(p_s8[0][k]);
			for (int i = 1; i < 3; i++) begin
				if ((COORD_BITS+1)'(p_s8[i][k]) < lo_v) lo_v = (COORD_BITS+1)'(p_s8[i][k]);
				if ((COORD_BITS+1)'(p_s8[i][k]) > hi_v) hi_v = (COORD_BITS+1)'(p_s8[i][k]);
			end
			face_n = face_n & (-(COORD_BITS+1)'(h[k]) < hi_v) & (lo_v < (COORD_BITS+1)'(h[k]));
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_edge
		btov_edge u_edge (
			.clk (clk),
			.h   (h),
			.p   (p_s9),
			.e   (e_s9[i]),
			.sep (sep[i])
		);
	end

	always_comb begin
		n_n[0] = NRAW_W'(e_s9[0][1]) * NRAW_W'(e_s9[1][2])
			- NRAW_W'(e_s9[0][2]) * NRAW_W'(e_s9[1][1]);
		n_n[1] = NRAW_W'(e_s9[0][2]) * NRAW_W'(e_s9[1][0])
			- NRAW_W'(e_s9[0][0]) * NRAW_W'(e_s9[1][2]);
		n_n[2] = NRAW_W'(e_s9[0][0]) * NRAW_W'(e_s9[1][1])
			- NRAW_W'(e_s9[0][1]) * NRAW_W'(e_s9[1][0]);
	end

	// normal rounded half up by two fraction bits, then projected
	always_comb begin
		d_n   = '0;
		rad_n = '0;
		nb    = '0;
		nr    = '0;
		na    = '0;
		for (int k = 0; k < 3; k++) begin
			nb    = (NRAW_W+1)'(n_s10[k]) + (NRAW_W+1)'(2);
			nr    = NRND_W'(nb >>> 2);
			na    = (nr < 0) ? -(NRND_W+1)'(nr) : (NRND_W+1)'(nr);
			d_n   = d_n + NDOT_W'(nr) * NDOT_W'(p0_s10[k]);
			rad_n = rad_n + NDOT_W'(h[k]) * NDOT_W'(na);
		end
	end

	always_ff @(posedge clk) begin
		origin_s1 <= tri_origin;
		origin_s2 <= origin_s1;
		origin_s3 <= origin_s2;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				w_s4[i][k] <= RIN_W'(vec_at(origin_s3, k)) + RIN_W'(r1[i][k]) - RIN_W'(c[k]);
				p_s8[i][k] <= sat_coord(r2[i][k]);
				p_s9[i][k] <= p_s8[i][k];
			end
		end
		for (int k = 0; k < 3; k++) begin
			e_s9[0][k] <= EDGE_W'(p_s8[1][k]) - EDGE_W'(p_s8[0][k]);
			e_s9[1][k] <= EDGE_W'(p_s8[2][k]) - EDGE_W'(p_s8[1][k]);
			e_s9[2][k] <= EDGE_W'(p_s8[0][k]) - EDGE_W'(p_s8[2][k]);
			n_s10[k]   <= n_n[k];
			p0_s10[k]  <= p_s9[0][k];
		end
		face_s9      <= face_n;
		face_s10     <= face_s9;
		face_s11     <= face_s10;
		d_s11        <= d_n;
		rad_s11      <= rad_n;
		overlaps_s12 <= face_s11 & ~sep[0] & ~sep[1] & ~sep[2]
			& ~((rad_s11 < d_s11) | (d_s11 < -rad_s11));
	end

	assign done     = vld_q[LAT-1];
	assign overlaps = overlaps_s12;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import btov_pkg::*;

	localparam int IDLE_TIMEOUT = 2000;
	localparam int TAIL_CYCLES  = 20;
	localparam int REG_UNUSED   = 3;

	typedef struct {
		logic [VEC_W-1:0] origin;
		logic [QV_W-1:0]  rotation;
		logic [VEC_W-1:0] va, vb, vc;
		int               gap;
		bit               drain;
	} tri_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [VEC_W-1:0]  tri_origin = '0;
	logic [QV_W-1:0]   tri_rotation = '0;
	logic [VEC_W-1:0]  vertex_a = '0, vertex_b = '0, vertex_c = '0;
	logic              done, overlaps;
	logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	box_triangle_overlap_unit u_top (.*);

	always #5 clk = ~clk;

	// box pose as the block should hold it
	logic [63:0] box_centre_q, box_rot_q, box_half_q;

	tri_t   pending_tris[$];
	bit     overlap_exp[$];
	tri_t   on_port;
	int     hold_cycles = 0;
	int     errors = 0, n_in = 0, n_hit = 0, n_miss = 0, idle_cnt = 0;
	bit     burst = 1'b0;

	function automatic longint fld(logic [63:0] w, int pos, int wd);
		logic [63:0] x;
		x = (w >> pos) & ((64'd1 << wd) - 64'd1);
		if (x[wd-1]) return longint'(x) - (longint'(1) << wd);
		return longint'(x);
	endfunction

	function automatic void cross_v(input longint a[3], input longint b[3], output longint r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic void quat_rotate(input longint q[4], input longint v[3],
			output longint o[3]);
		longint u[3], uv[3], uuv[3], acc;
		u[0] = q[1]; u[1] = q[2]; u[2] = q[3];
		cross_v(u, v, uv);
		cross_v(u, uv, uuv);
		for (int i = 0; i < 3; i++) begin
			acc = v[i] * (longint'(1) << (2 * QUAT_FRAC));
			acc += 2 * (q[0] * uv[i] + uuv[i]);
			o[i] = (acc + (longint'(1) << (2 * QUAT_FRAC - 1))) >>> (2 * QUAT_FRAC);
		end
	endfunction

	function automatic longint labs(longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic bit axis_separates(input longint h[3], input longint p[3][3],
			input longint ax[3]);
		longint r, lo, hi, d;
		if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) return 1'b0;
		r = h[0] * labs(ax[0]) + h[1] * labs(ax[1]) + h[2] * labs(ax[2]);
		for (int i = 0; i < 3; i++) begin
			d = p[i][0] * ax[0] + p[i][1] * ax[1] + p[i][2] * ax[2];
			if (i == 0 || d < lo) lo = d;
			if (i == 0 || d > hi) hi = d;
		end
		return r < lo || hi < -r;
	endfunction

	function automatic bit predict_overlap(tri_t t);
		longint qb[4], qt[4], c[3], h[3], o[3], v[3], w[3], p[3][3];
		longint e[3][3], ax[3], n[3], lo, hi, d, r;
		logic [VEC_W-1:0] vw;
		for (int k = 0; k < 4; k++) begin
			qb[k] = fld(box_rot_q, k * QUAT_BITS, QUAT_BITS);
			qt[k] = fld(t.rotation, k * QUAT_BITS, QUAT_BITS);
		end
		for (int k = 0; k < 3; k++) begin
			c[k] = fld(box_centre_q, k * COORD_BITS, COORD_BITS);
			h[k] = fld(box_half_q, k * COORD_BITS, COORD_BITS);
			o[k] = fld(t.origin, k * COORD_BITS, COORD_BITS);
		end
		for (int i = 0; i < 3; i++) begin
			vw = (i == 0) ? t.va : (i == 1) ? t.vb : t.vc;
			for (int k = 0; k < 3; k++) v[k] = fld(vw, k * COORD_BITS, COORD_BITS);
			quat_rotate(qt, v, w);
			for (int k = 0; k < 3; k++) w[k] = o[k] + w[k] - c[k];
			quat_rotate(qb, w, v);
			for (int k = 0; k < 3; k++)
				p[i][k] = v[k] > COORD_MAX ? COORD_MAX : (v[k] < COORD_MIN ? COORD_MIN : v[k]);
		end
		// box face axes, strict on both sides
		for (int k = 0; k < 3; k++) begin
			lo = p[0][k]; hi = p[0][k];
			for (int i = 1; i < 3; i++) begin
				if (p[i][k] < lo) lo = p[i][k];
				if (p[i][k] > hi) hi = p[i][k];
			end
			if (!(-h[k] < hi && lo < h[k])) return 1'b0;
		end
		for (int k = 0; k < 3; k++) begin
			e[0][k] = p[1][k] - p[0][k];
			e[1][k] = p[2][k] - p[1][k];
			e[2][k] = p[0][k] - p[2][k];
		end
		for (int i = 0; i < 3; i++) begin
			ax[0] = 0; ax[1] = -e[i][2]; ax[2] = e[i][1];
			if (axis_separates(h, p, ax)) return 1'b0;
			ax[0] = e[i][2]; ax[1] = 0; ax[2] = -e[i][0];
			if (axis_separates(h, p, ax)) return 1'b0;
			ax[0] = -e[i][1]; ax[1] = e[i][0]; ax[2] = 0;
			if (axis_separates(h, p, ax)) return 1'b0;
		end
		cross_v(e[0], e[1], n);
		for (int k = 0; k < 3; k++) n[k] = (n[k] + 2) >>> 2;
		d = n[0] * p[0][0] + n[1] * p[0][1] + n[2] * p[0][2];
		r = h[0] * labs(n[0]) + h[1] * labs(n[1]) + h[2] * labs(n[2]);
		return !(r < d || d < -r);
	endfunction

	function automatic logic [VEC_W-1:0] pack3(longint x, longint y, longint z);
		return {COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)};
	endfunction

	function automatic logic [QV_W-1:0] pack4(longint w, longint x, longint y, longint z);
		return {QUAT_BITS'(z), QUAT_BITS'(y), QUAT_BITS'(x), QUAT_BITS'(w)};
	endfunction

	function automatic longint srand(int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [QV_W-1:0] rand_quat();
		if ($urandom_range(0, 3) == 0) return ROT_RESET;
		return pack4(srand(16384), srand(16384), srand(16384), srand(16384));
	endfunction

	// mostly small triangles near the box so both outcomes are common
	function automatic tri_t rand_tri();
		tri_t t;
		longint c[3];
		for (int k = 0; k < 3; k++) c[k] = fld(box_centre_q, k * COORD_BITS, COORD_BITS);
		if ($urandom_range(0, 9) == 0) begin
			t.origin = rand64(); t.rotation = rand64();
			t.va = rand64(); t.vb = rand64(); t.vc = rand64();
		end else begin
			t.origin = pack3(c[0] + srand(3072), c[1] + srand(3072), c[2] + srand(3072));
			t.rotation = rand_quat();
			t.va = pack3(srand(2048), srand(2048), srand(2048));
			t.vb = pack3(srand(2048), srand(2048), srand(2048));
			t.vc = ($urandom_range(0, 15) == 0) ? t.vb :
				pack3(srand(2048), srand(2048), srand(2048));
		end
		if ($urandom_range(0, 40) == 0) burst = ~burst;
		t.gap = burst ? 0 : $urandom_range(0, 13);
		t.drain = ($urandom_range(0, 199) == 0);
		return t;
	endfunction

	task automatic add_random(int n);
		for (int i = 0; i < n; i++) pending_tris.insert(pending_tris.size(), rand_tri());
	endtask

	task automatic add_tri(logic [VEC_W-1:0] o, logic [QV_W-1:0] q,
			logic [VEC_W-1:0] a, logic [VEC_W-1:0] b, logic [VEC_W-1:0] c);
		tri_t t;
		t.origin = o; t.rotation = q; t.va = a; t.vb = b; t.vc = c;
		t.gap = $urandom_range(0, 3); t.drain = 1'b0;
		pending_tris.insert(pending_tris.size(), t);
	endtask

	task automatic reg_write(int idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 8); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_BOX_CENTER) box_centre_q = {1'b0, val[62:0]};
		else if (idx == REG_BOX_ROT) box_rot_q = val;
		else if (idx == REG_BOX_HALF) box_half_q = {1'b0, val[62:0]};
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending_tris.size() != 0 || overlap_exp.size() != 0 || start);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// triangle driver
	always @(posedge clk) begin
		bit nxt;
		nxt = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				overlap_exp.insert(overlap_exp.size(), predict_overlap(on_port));
				n_in++;
			end
			if (start && busy) nxt = 1'b1;
			else if (hold_cycles > 0) hold_cycles--;
			else if (pending_tris.size() > 0 &&
					!(pending_tris[0].drain && (overlap_exp.size() > 0 || start))) begin
				on_port = pending_tris.pop_front();
				hold_cycles = on_port.gap;
				tri_origin <= on_port.origin;
				tri_rotation <= on_port.rotation;
				vertex_a <= on_port.va;
				vertex_b <= on_port.vb;
				vertex_c <= on_port.vc;
				nxt = 1'b1;
			end
		end
		start <= nxt;
	end

	// result monitor
	always @(posedge clk) begin
		bit want;
		if (arst_n && done) begin
			if (overlaps) n_hit++; else n_miss++;
			if (overlap_exp.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual overlaps=%0b",
					$time, overlaps);
				errors++;
			end else begin
				want = overlap_exp.pop_front();
				if (overlaps !== want) begin
					$display("%0t: overlaps mismatch, expected %0b, actual %0b",
						$time, want, overlaps);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready) || !arst_n) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_TIMEOUT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		logic [VEC_W-1:0] z3, one3, max3, min3, all1;
		box_centre_q = '0; box_rot_q = 64'(ROT_RESET); box_half_q = '0;
		z3 = '0;
		one3 = pack3(1024, 1024, 1024);
		max3 = pack3(COORD_MAX, COORD_MAX, COORD_MAX);
		min3 = pack3(COORD_MIN, COORD_MIN, COORD_MIN);
		all1 = '1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pose: zero half extents
		add_tri(z3, ROT_RESET, z3, z3, z3);
		add_tri(z3, ROT_RESET, pack3(-1, -1, 0), pack3(1, -1, 0), pack3(0, 1, 0));
		wait_idle();

		reg_write(REG_BOX_HALF, pack3(1024, 1536, 2048));
		// inside, far away, degenerate, collinear, face plane touching, extremes
		add_tri(z3, ROT_RESET, pack3(-256, 0, 0), pack3(256, 0, 0), pack3(0, 256, 0));
		add_tri(pack3(8000, 0, 0), ROT_RESET, z3, one3, pack3(0, 512, 0));
		add_tri(z3, ROT_RESET, one3, one3, one3);
		add_tri(z3, ROT_RESET, pack3(-100, -100, -100), z3, pack3(100, 100, 100));
		add_tri(z3, ROT_RESET, pack3(1024, -50, 0), pack3(1024, 50, 0), pack3(1024, 0, 50));
		add_tri(z3, ROT_RESET, pack3(1023, -50, 0), pack3(1023, 50, 0), pack3(1023, 0, 50));
		add_tri(pack3(0, 0, 3000), ROT_RESET, pack3(-4000, 0, 0), pack3(4000, 0, 0),
			pack3(0, 0, -4000));
		add_tri(pack3(1800, 1800, 0), ROT_RESET, pack3(-600, 0, 0), pack3(0, -600, 0),
			pack3(0, 0, 600));
		add_tri(pack3(0, 0, 2300), pack4(11585, 11585, 0, 0), pack3(-300, 0, 0),
			pack3(300, 0, 0), pack3(0, 300, 0));
		add_tri(max3, 64'h7FFF7FFF7FFF7FFF, max3, max3, min3);
		add_tri(min3, '1, min3, max3, all1);
		add_tri(all1, '0, all1, z3, max3);
		add_tri(z3, pack4(0, 16384, 0, 0), max3, min3, z3);
		add_tri(max3, 64'h8000800080008000, min3, min3, max3);
		add_random(300);
		wait_idle();

		reg_write(REG_BOX_CENTER, pack3(srand(20000), srand(20000), srand(20000)));
		reg_write(REG_BOX_ROT, rand_quat());
		reg_write(REG_BOX_HALF, pack3($urandom_range(0, 4096), $urandom_range(0, 4096),
			$urandom_range(0, 4096)));
		add_random(400);
		wait_idle();

		// unmapped register must leave the pose alone
		reg_write(REG_UNUSED, rand64());
		reg_write(REG_BOX_CENTER, max3);
		reg_write(REG_BOX_HALF, max3);
		reg_write(REG_BOX_ROT, '1);
		add_random(150);
		wait_idle();

		reg_write(REG_BOX_CENTER, min3);
		reg_write(REG_BOX_HALF, all1);
		reg_write(REG_BOX_ROT, 64'h7FFF7FFF7FFF7FFF);
		add_random(150);
		wait_idle();

		reg_write(REG_BOX_CENTER, pack3(srand(500), srand(500), srand(500)));
		reg_write(REG_BOX_ROT, pack4(srand(16384), srand(16384), srand(16384), srand(16384)));
		reg_write(REG_BOX_HALF, pack3(2048, 2048, 2048));
		add_random(200);
		pending_tris[100].drain = 1'b1;
		add_random(200);
		wait_idle();

		$display("tb: %0d triangles over 6 box poses (reset, extremes, negative extents)", n_in);
		$display("tb: %0d overlapping and %0d separated results", n_hit, n_miss);
		if (errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

endmodule
